// ----- rtl/svt_pkg.sv -----
package svt_pkg;

    localparam int DEPTH   = 16;
    localparam int VAL_W   = 32;
    localparam int POS_W   = 5;
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_SEARCH  = 2'd2,
        CMD_DISPLAY = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_DISPLAY
    } state_t;

    typedef struct packed {
        cmd_t               command;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [4:0]         position;
        logic signed [31:0] entry_value;
        logic [4:0]         entry_count;
        logic               last;
    } res_t;

    // broadcast to every cell
    typedef struct packed {
        op_t                    op;
        logic signed [VAL_W-1:0] value;
    } ctrl_t;

    // compare results of one cell against the broadcast value
    typedef struct packed {
        logic le;
        logic lt;
        logic eq;
    } flag_t;

endpackage

// ----- rtl/svt_cell.sv -----
module svt_cell (
    input  logic                           clk,
    input  svt_pkg::ctrl_t                 ctrl,
    input  logic                           valid,
    input  logic                           tail,
    input  logic                           left_le,
    input  logic signed [svt_pkg::VAL_W-1:0] left_entry,
    input  logic signed [svt_pkg::VAL_W-1:0] right_entry,
    input  logic signed [svt_pkg::VAL_W-1:0] head_entry,
    output logic signed [svt_pkg::VAL_W-1:0] entry,
    output svt_pkg::flag_t                 flags
);

    logic signed [svt_pkg::VAL_W-1:0] entry_reg;
    logic signed [svt_pkg::VAL_W-1:0] entry_next;

    assign entry    = entry_reg;
    assign flags.le = valid && (entry_reg <= ctrl.value);
    assign flags.lt = valid && (entry_reg < ctrl.value);
    assign flags.eq = valid && (entry_reg == ctrl.value);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctrl.op)
            svt_pkg::OP_INSERT:
            begin
                // entries above the insert point move up by one
                if (!flags.le)
                begin
                    entry_next = left_le ? ctrl.value : left_entry;
                end
            end
            svt_pkg::OP_DELETE:
            begin
                // entries from the first match onward move down by one
                if (!flags.lt)
                begin
                    entry_next = right_entry;
                end
            end
            svt_pkg::OP_ROTATE:
            begin
                if (valid)
                begin
                    entry_next = tail ? head_entry : right_entry;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/sorted_value_table_top.sv -----
// channel  | ports                     | direction | meaning
// ---------+---------------------------+-----------+---------------------------------
// request  | start, request; busy (out) | in        | command and operand, taken when
//          |                           |           | start is high and busy is low
// result   | result_strobe, result     | out       | one result per strobe cycle
//
// insert, delete and search pass through the cell chain; the result
// shows on the next cycle and busy stays low, so requests can follow back to back
// display holds busy high while rotating the chain one place per cycle
// and emitting cell zero each cycle, so the table is back in order when busy falls
// display of an empty table answers on the next cycle without raising busy
// reset clears the count and sequencer, not the cells; the receiver cannot stall
module sorted_value_table_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  svt_pkg::req_t request,
    output logic          busy,
    output logic          result_strobe,
    output svt_pkg::res_t result
);

    localparam int DEPTH = svt_pkg::DEPTH;
    localparam int CNT_W = svt_pkg::CNT_W;

    // sequencer and count
    svt_pkg::state_t   state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  disp_idx_reg, disp_idx_next;

    // registered result
    svt_pkg::res_t     res_reg, res_next;
    logic              strobe_reg, strobe_next;

    // cell chain wiring
    svt_pkg::ctrl_t                   ctrl;
    logic signed [svt_pkg::VAL_W-1:0] cell_entry [DEPTH];
    svt_pkg::flag_t                   cell_flags [DEPTH];
    logic [DEPTH-1:0]                 le_vec;
    logic [DEPTH-1:0]                 eq_vec;

    logic              accept;
    logic              full;
    logic              found;
    logic [CNT_W-1:0]  match_pos;
    logic [CNT_W-1:0]  disp_pos;

    assign accept   = start && (state_reg == svt_pkg::S_IDLE);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign disp_pos = disp_idx_reg + CNT_W'(1);

    assign busy          = (state_reg == svt_pkg::S_DISPLAY);
    assign result_strobe = strobe_reg;
    assign result        = res_reg;

    // the chain: cell i holds the entry at position i + 1
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                             left_le;
        logic signed [svt_pkg::VAL_W-1:0] left_entry;
        logic signed [svt_pkg::VAL_W-1:0] right_entry;

        if (i == 0)
        begin : g_head
            assign left_le    = 1'b1;
            assign left_entry = ctrl.value;
        end
        else
        begin : g_body
            assign left_le    = le_vec[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_end
            assign right_entry = cell_entry[i];
        end
        else
        begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        svt_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (CNT_W'(i) < count_reg),
            .tail        (CNT_W'(i + 1) == count_reg),
            .left_le     (left_le),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .head_entry  (cell_entry[0]),
            .entry       (cell_entry[i]),
            .flags       (cell_flags[i])
        );

        assign le_vec[i] = cell_flags[i].le;
        assign eq_vec[i] = cell_flags[i].eq;
    end

    // equal entries sit next to each other, so the first match is where the
    // run of matches begins
    assign found = |eq_vec;

    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (eq_vec[i] && ((i == 0) || !eq_vec[(i == 0) ? 0 : i - 1]))
            begin
                match_pos = match_pos | CNT_W'(i + 1);
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            svt_pkg::S_IDLE:
            begin
                if (accept && (request.command == svt_pkg::CMD_DISPLAY) &&
                    (count_reg != '0))
                begin
                    state_next = svt_pkg::S_DISPLAY;
                end
            end
            svt_pkg::S_DISPLAY:
            begin
                if (disp_pos == count_reg)
                begin
                    state_next = svt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = svt_pkg::S_IDLE;
            end
        endcase
    end

    // outputs, chain control, count
    always_comb
    begin
        ctrl.op           = svt_pkg::OP_HOLD;
        ctrl.value        = request.value;
        count_next        = count_reg;
        disp_idx_next     = disp_idx_reg;
        strobe_next       = 1'b0;
        res_next.status   = svt_pkg::STAT_OK;
        res_next.position = '0;
        res_next.entry_value = '0;
        res_next.entry_count = 5'(count_reg);
        res_next.last     = 1'b1;

        unique case (state_reg)
            svt_pkg::S_IDLE:
            begin
                disp_idx_next = '0;
                if (accept)
                begin
                    strobe_next = 1'b1;
                    unique case (request.command)
                        svt_pkg::CMD_INSERT:
                        begin
                            if (full)
                            begin
                                res_next.status = svt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ctrl.op    = svt_pkg::OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                                res_next.entry_count = 5'(count_next);
                            end
                        end
                        svt_pkg::CMD_DELETE:
                        begin
                            if (found)
                            begin
                                ctrl.op    = svt_pkg::OP_DELETE;
                                count_next = count_reg - CNT_W'(1);
                                res_next.entry_count = 5'(count_next);
                            end
                            else
                            begin
                                res_next.status = svt_pkg::STAT_NOT_FOUND;
                            end
                        end
                        svt_pkg::CMD_SEARCH:
                        begin
                            if (found)
                            begin
                                res_next.position    = 5'(match_pos);
                                res_next.entry_value = request.value;
                            end
                            else
                            begin
                                res_next.status = svt_pkg::STAT_NOT_FOUND;
                            end
                        end
                        svt_pkg::CMD_DISPLAY:
                        begin
                            // non-empty display streams from the sequencer
                            if (count_reg == '0)
                            begin
                                res_next.status = svt_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                strobe_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b0;
                        end
                    endcase
                end
            end
            svt_pkg::S_DISPLAY:
            begin
                ctrl.op              = svt_pkg::OP_ROTATE;
                strobe_next          = 1'b1;
                res_next.position    = 5'(disp_pos);
                res_next.entry_value = cell_entry[0];
                res_next.last        = (disp_pos == count_reg);
                disp_idx_next        = disp_pos;
            end
            default:
            begin
                ctrl.op = svt_pkg::OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= svt_pkg::S_IDLE;
            count_reg    <= '0;
            disp_idx_reg <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            disp_idx_reg <= disp_idx_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // the table never holds more than its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // every display cycle yields a result on the next cycle
    a_display_streams: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> result_strobe)
        else $error("display cycle without result");

    // single-result commands answer on the next cycle
    a_single_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command != svt_pkg::CMD_DISPLAY)) |=> result_strobe)
        else $error("missing result for request");

    // the final result of a display ends the busy period
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |-> !busy)
        else $error("busy after final result");

endmodule
